FILE: rtl/zcd_pkg.sv
// Shared constants for the zero-crossing detector: field widths, config map, result queue.
`timescale 1ns / 1ps
`default_nettype none
package zcd_pkg;

    // Fixed field and register widths
    localparam int ROW_BITS       = 12;
    localparam int FW_BITS        = 11;
    localparam int FH_BITS        = 13;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;

    // Register map
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 11'd128;
    localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 13'd96;

    localparam int                 MIN_DIM    = 3;
    localparam logic [FH_BITS-1:0] MAX_HEIGHT = 13'd4096;

    // Result queue between the detect stage and the output port
    localparam int RES_DEPTH    = 4;
    localparam int RES_PTR_BITS = 2;
    localparam int RES_CNT_BITS = 3;

endpackage
`default_nettype wire

FILE: rtl/zcd_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module zcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

FILE: rtl/zcd_res_fifo.sv
// Small result queue that decouples the detect stage from a stalled receiver.
`timescale 1ns / 1ps
`default_nettype none
module zcd_res_fifo
    import zcd_pkg::*;
#(
    parameter int DATA_BITS = 22
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire logic [DATA_BITS-1:0]    push_data,
    input  wire logic                    pop,
    output logic      [DATA_BITS-1:0]    head,
    output logic      [RES_CNT_BITS-1:0] count
);

    logic [DATA_BITS-1:0]    store [RES_DEPTH];
    logic [RES_PTR_BITS-1:0] wr_ptr_reg;
    logic [RES_PTR_BITS-1:0] rd_ptr_reg;
    logic [RES_CNT_BITS-1:0] count_reg;
    logic [RES_CNT_BITS-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + RES_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - RES_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + RES_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = store[rd_ptr_reg];
    assign count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != RES_CNT_BITS'(RES_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue underflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("result queue pointers out of step with count");

endmodule
`default_nettype wire

FILE: rtl/zero_crossing_detector_core.sv
// Top level of the 4-neighbour zero-crossing detector on a raster sample stream.
//
// Samples enter on sample/sample_valid/sample_stall, one per pixel in raster order.
// For each interior pixel whose left/right or upper/lower neighbours have strictly
// opposite nonzero signs, the pixel's col/row goes out on result_valid/result_stall.
// Pixel (x,y) is decided when pixel (x,y+1) is transferred in, so results keep
// raster order. frame_width and frame_height are written through cfg_we/cfg_index/
// cfg_data while the block is idle; values outside 3..MAX_WIDTH and 3..4096 clamp.
// Throughput: one sample per clock while sample_stall is low. Each sample does one
// read-modify-write of the line RAM (older and recent rows packed in one word, read
// at col and col+1). A result passes the detect stage registers and then the result
// queue; result_valid rises once the queue holds it.
// A four-entry result queue absorbs receiver stalls; sample_stall rises only when
// the queue plus the item in the detect stage could fill it.
// Reset clears the counters and restores the default frame size; the line RAM is
// not cleared, so the first two rows of the first frame report nothing anyway.
`timescale 1ns / 1ps
`default_nettype none
module zero_crossing_detector_core
    import zcd_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]       col,
    output logic [ROW_BITS-1:0]                row
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WB       = $clog2(MAX_WIDTH + 1);
    localparam int RES_BITS = COL_BITS + ROW_BITS;

    function automatic logic opposite(input logic [SAMPLE_BITS-1:0] a,
                                      input logic [SAMPLE_BITS-1:0] b);
        logic a_neg;
        logic a_pos;
        logic b_neg;
        logic b_pos;
        a_neg = a[SAMPLE_BITS-1];
        a_pos = !a[SAMPLE_BITS-1] && (|a);
        b_neg = b[SAMPLE_BITS-1];
        b_pos = !b[SAMPLE_BITS-1] && (|b);
        return (a_pos && b_neg) || (a_neg && b_pos);
    endfunction

    // Configuration
    logic [FW_BITS-1:0] frame_width_reg;
    logic [FH_BITS-1:0] frame_height_reg;

    // Raster position and row y-1 value of the column to the left
    logic [COL_BITS-1:0]    col_count_reg;
    logic [COL_BITS-1:0]    col_count_next;
    logic [ROW_BITS-1:0]    row_count_reg;
    logic [ROW_BITS-1:0]    row_count_next;
    logic [SAMPLE_BITS-1:0] left_hold_reg;

    // Detect stage (RAM read data arrives here)
    logic                   s1_valid_reg;
    logic                   s1_check_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [COL_BITS-1:0]    s1_col_reg;
    logic [ROW_BITS-1:0]    s1_row_reg;

    logic [WB-1:0]          w_eff;
    logic [FH_BITS-1:0]     h_eff;
    logic [COL_BITS-1:0]    c0;
    logic [ROW_BITS-1:0]    r0;
    logic [WB-1:0]          c0_plus;
    logic [FH_BITS-1:0]     r0_plus;
    logic                   last_col;
    logic                   last_row;
    logic                   check0;
    logic                   accept;

    logic [2*SAMPLE_BITS-1:0] rd_word_a;
    logic [2*SAMPLE_BITS-1:0] rd_word_b;
    logic [SAMPLE_BITS-1:0]   above;
    logic [SAMPLE_BITS-1:0]   up2;
    logic [SAMPLE_BITS-1:0]   right;
    logic                     found;
    logic                     res_push;
    logic                     res_pop;
    logic [RES_BITS-1:0]      res_head;
    logic [RES_CNT_BITS-1:0]  res_count;

    assign accept = sample_valid && !sample_stall;

    // Effective geometry and position of the incoming sample
    always_comb
    begin
        if (frame_width_reg < FW_BITS'(MIN_DIM))
        begin
            w_eff = WB'(MIN_DIM);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WB'(frame_width_reg);
        end

        if (frame_height_reg < FH_BITS'(MIN_DIM))
        begin
            h_eff = FH_BITS'(MIN_DIM);
        end
        else if (frame_height_reg > MAX_HEIGHT)
        begin
            h_eff = MAX_HEIGHT;
        end
        else
        begin
            h_eff = frame_height_reg;
        end

        // A shrunken frame restarts the column or row at zero
        c0 = (WB'(col_count_reg) >= w_eff) ? '0 : col_count_reg;
        r0 = (FH_BITS'(row_count_reg) >= h_eff) ? '0 : row_count_reg;

        c0_plus  = WB'(c0) + WB'(1);
        r0_plus  = FH_BITS'(r0) + FH_BITS'(1);
        last_col = c0_plus >= w_eff;
        last_row = r0_plus >= h_eff;
        check0   = (r0 >= ROW_BITS'(2)) && (c0 != '0) && !last_col;

        col_count_next = last_col ? '0 : c0_plus[COL_BITS-1:0];
        if (last_col)
        begin
            row_count_next = last_row ? '0 : r0_plus[ROW_BITS-1:0];
        end
        else
        begin
            row_count_next = r0;
        end
    end

    // Line RAM word: {row y-2, row y-1}. Consecutive samples touch different
    // columns, so the write-back never meets a read of the same entry.
    zcd_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk       (clk),
        .we        (s1_valid_reg),
        .wr_addr   (s1_col_reg),
        .wr_data   ({above, s1_sample_reg}),
        .rd_addr_a (c0),
        .rd_data_a (rd_word_a),
        .rd_addr_b (c0_plus[COL_BITS-1:0]),
        .rd_data_b (rd_word_b)
    );

    assign above = rd_word_a[SAMPLE_BITS-1:0];
    assign up2   = rd_word_a[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign right = rd_word_b[SAMPLE_BITS-1:0];

    assign found    = s1_check_reg
                    && (opposite(left_hold_reg, right) || opposite(up2, s1_sample_reg));
    assign res_push = s1_valid_reg && found;
    assign res_pop  = result_valid && !result_stall;

    zcd_res_fifo #(
        .DATA_BITS (RES_BITS)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data ({s1_col_reg, s1_row_reg}),
        .pop       (res_pop),
        .head      (res_head),
        .count     (res_count)
    );

    // Hold off when the queue plus a possible result in flight could fill it
    assign sample_stall = ({1'b0, res_count} + (RES_CNT_BITS + 1)'(s1_valid_reg))
                          > (RES_CNT_BITS + 1)'(RES_DEPTH - 1);
    assign result_valid = res_count != '0;
    assign col          = res_head[RES_BITS-1:ROW_BITS];
    assign row          = res_head[ROW_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            left_hold_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s1_check_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_BITS-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_BITS-1:0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
            if (s1_valid_reg)
            begin
                left_hold_reg <= above;
            end
            s1_valid_reg <= accept;
            s1_check_reg <= accept && check0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_col_reg    <= c0;
            s1_row_reg    <= r0 - ROW_BITS'(1);
        end
    end

    a_no_ram_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> (c0 != s1_col_reg)
                                  && (c0_plus[COL_BITS-1:0] != s1_col_reg))
        else $error("line RAM write-back collides with a read");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (col != '0) && (row != '0))
        else $error("result on a border pixel");

    a_push_checked: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> s1_check_reg && $past(accept))
        else $error("result from an item that was not an interior transfer");

endmodule
`default_nettype wire

FILE: tb/zcd_checker.sv
// Checker for the zero-crossing detector: predicts crossings and compares each result transfer.
`timescale 1ns / 1ps
module zcd_checker
    import zcd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      sample_valid,
    input  logic                      sample_stall,
    input  logic signed [15:0]        sample,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  logic [9:0]                col,
    input  logic [ROW_BITS-1:0]       row,
    output int                        fail_count,
    output int                        pending
);
    localparam int LINE_DEPTH = 1024;

    typedef struct packed {
        logic [9:0]          col;
        logic [ROW_BITS-1:0] row;
    } crossing_t;

    logic signed [15:0] older_row  [0:LINE_DEPTH-1];
    logic signed [15:0] recent_row [0:LINE_DEPTH-1];
    logic signed [15:0] left_level;
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [FW_BITS-1:0] frame_w;
    logic [FH_BITS-1:0] frame_h;
    crossing_t          crossing_q [$];

    function automatic bit opposite_signs(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
        return (a > 0 && b < 0) || (a < 0 && b > 0);
    endfunction

    // Advance the raster position by one pixel; queue the pixel one row up if it crosses.
    task automatic predict_crossing(input logic signed [15:0] level);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        logic signed [15:0] above;
        logic signed [15:0] up2;
        crossing_t          hit;
        w = 32'(frame_w);
        h = 32'(frame_h);
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_HEIGHT) h = 32'(MAX_HEIGHT);
        // geometry may have shrunk under the counters
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        above = recent_row[c];
        up2   = older_row[c];
        if (r >= 2 && c >= 1 && c + 1 < w) begin
            if (opposite_signs(left_level, recent_row[c + 1]) || opposite_signs(up2, level))
            begin
                hit.col = 10'(c);
                hit.row = ROW_BITS'(r - 1);
                crossing_q.push_back(hit);
            end
        end
        older_row[c]  = above;
        recent_row[c] = level;
        left_level    = above;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge clk or negedge rst_n) begin
        crossing_t want;
        int        errs;
        if (!rst_n) begin
            col_pos    = 0;
            row_pos    = 0;
            left_level = '0;
            frame_w    = FRAME_WIDTH_RST;
            frame_h    = FRAME_HEIGHT_RST;
            crossing_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            errs = 0;
            if (cfg_we) begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    frame_w = cfg_data[FW_BITS-1:0];
                else if (cfg_index == CFG_FRAME_HEIGHT)
                    frame_h = cfg_data[FH_BITS-1:0];
            end
            if (sample_valid && !sample_stall)
                predict_crossing(sample);
            if (result_valid && !result_stall) begin
                if (crossing_q.size() == 0) begin
                    $error("unexpected result transfer: col %0d row %0d", col, row);
                    errs++;
                end
                else begin
                    want = crossing_q.pop_front();
                    if (col !== want.col) begin
                        $error("col: expected %0d, got %0d", want.col, col);
                        errs++;
                    end
                    if (row !== want.row) begin
                        $error("row: expected %0d, got %0d", want.row, row);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= crossing_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the zero-crossing detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import zcd_pkg::*;

    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int QUIET_FROM    = 900;
    localparam int FILL_WIDTH    = 128;
    localparam int WIDE_ITEMS    = 2 * FILL_WIDTH;

    // Three 3x3 frames: both-axis crossing, zeros and equal signs, vertical only
    localparam logic signed [15:0] PROBE [0:26] = '{
        16'sd0,  16'sd32767, 16'sd0,
        -16'sd1, 16'sd0,     16'sd1,
        16'sd5,  -16'sd32768, 16'sd7,
        16'sd0,  16'sd0,     16'sd0,
        16'sd1,  16'sd2,     16'sd1,
        16'sd0,  16'sd0,     16'sd0,
        16'sd3,  -16'sd256,  16'sd9,
        16'sd0,  16'sd4,     16'sd0,
        16'sd2,  16'sd256,   16'sd1
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      sample_valid;
    logic                      sample_stall;
    logic signed [15:0]        sample;
    logic                      result_valid;
    logic                      result_stall;
    logic [9:0]                col;
    logic [ROW_BITS-1:0]       row;
    int                        fail_count;
    int                        pending;

    bit quiet;
    bit gappy;
    bit hold_req;
    bit hold_done;
    int random_sent;

    zero_crossing_detector_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .col          (col),
        .row          (row)
    );

    zcd_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .col          (col),
        .row          (row),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 9))
            0, 1:    return 16'd0;
            2:       return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            3:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            4, 5:    return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0]  val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one sample and return at the edge where it transfers.
    task automatic send_level(input logic [15:0] level);
        @(negedge clk);
        if (gappy && !quiet && $urandom_range(0, 4) == 0) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= level;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
    endtask

    // Stop offering, wait for every predicted crossing, then let the pipe empty.
    task automatic settle();
        @(negedge clk);
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Effective widths stay within the columns filled at the start of the run.
    task automatic pick_geometry();
        logic [CFG_DATA_BITS-1:0] fw;
        logic [CFG_DATA_BITS-1:0] fh;
        case ($urandom_range(0, 19))
            14: begin
                fw = 13'($urandom_range(0, 2));
                fh = 13'($urandom_range(0, 2));
            end
            15: begin
                // upper bits fall outside the width register
                fw = {2'($urandom), 11'($urandom_range(3, FILL_WIDTH))};
                fh = 13'($urandom_range(3, 8));
            end
            16: begin
                fw = 13'(FILL_WIDTH);
                fh = 13'd4096;
            end
            17: begin
                fw = 13'($urandom_range(3, 12));
                fh = 13'($urandom_range(4097, 8191));
            end
            18, 19: begin
                fw = 13'($urandom_range(13, 64));
                fh = 13'($urandom_range(3, 40));
            end
            default: begin
                fw = 13'($urandom_range(3, 12));
                fh = 13'($urandom_range(3, 8));
            end
        endcase
        case ($urandom_range(0, 2))
            0: write_reg(CFG_FRAME_WIDTH, fw);
            1: write_reg(CFG_FRAME_HEIGHT, fh);
            default: begin
                write_reg(CFG_FRAME_WIDTH, fw);
                write_reg(CFG_FRAME_HEIGHT, fh);
            end
        endcase
    endtask

    // Result side: random stall bursts, calm stretches, and one long hold-off.
    initial
    begin
        result_stall = 1'b0;
        hold_done    = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (!quiet) begin
                case ($urandom_range(0, 15))
                    0, 1, 2: begin
                        result_stall <= 1'b1;
                        repeat ($urandom_range(1, 6)) @(negedge clk);
                        result_stall <= 1'b0;
                    end
                    3: repeat (40) @(negedge clk);
                    default: ;
                endcase
            end
        end
    end

    initial
    begin
        int len;
        int mag;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_FRAME_WIDTH;
        cfg_data     = '0;
        sample_valid = 1'b0;
        sample       = '0;
        quiet        = 1'b0;
        gappy        = 1'b1;
        hold_req     = 1'b0;
        random_sent  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Both registers below range: 3x3 frames
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        for (int i = 0; i < 27; i++)
            send_level(PROBE[i]);
        settle();

        // Two full rows from frame start; every line entry a later frame reaches is written
        write_reg(CFG_FRAME_WIDTH, 13'(FILL_WIDTH));
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        for (int i = 0; i < WIDE_ITEMS; i++)
            send_level(pick_level());
        settle();

        // Dense crossings (++-- along each row) while the result side holds off
        write_reg(CFG_FRAME_WIDTH, 13'd8);
        write_reg(CFG_FRAME_HEIGHT, 13'd6);
        hold_req = 1'b1;
        for (int i = 0; i < 64; i++) begin
            mag = $urandom_range(1, 32767);
            send_level((i % 4 < 2) ? 16'(mag) : 16'(-mag));
        end
        settle();

        while (random_sent < RANDOM_ITEMS) begin
            pick_geometry();
            quiet = (random_sent >= QUIET_FROM);
            gappy = ($urandom_range(0, 2) != 0);
            len = $urandom_range(10, 100);
            for (int i = 0; i < len; i++) begin
                send_level(pick_level());
                random_sent++;
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
